// ----- src/dsat_pkg.sv -----
// ----------------------------------------------------------------------------
// dsat_pkg
// Shared constants, codes, interleave tables and controller/datapath
// command and status types for the disk sector address translator.
// ----------------------------------------------------------------------------
package dsat_pkg;

    // Field widths
    localparam int SPT_W    = 5;
    localparam int TC_W     = 6;
    localparam int ILV_W    = 2;
    localparam int MODE_W   = 2;
    localparam int TRACK_W  = 8;
    localparam int SECTOR_W = 8;
    localparam int BLOCK_W  = 16;
    localparam int OFFSET_W = 18;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Default sector size in bytes
    localparam int SECTOR_BYTES_DEF = 256;

    // Linear sector number: track * spt + physical, up to 255 * 31 + 15
    localparam int LIN_W = 13;
    // Image size in sectors: track_count * spt, up to 63 * 31
    localparam int CAP_W = 11;

    // Block divider: 16 dividend bits, four bits per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = BLOCK_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ILV = 2'd2;

    // Configuration reset values
    localparam logic [SPT_W-1:0] SPT_RST = 5'd16;
    localparam logic [TC_W-1:0]  TC_RST  = 6'd35;
    localparam logic [ILV_W-1:0] ILV_RST = 2'd0;

    // Interleave orders
    localparam logic [ILV_W-1:0] ILV_DOS   = 2'd1;
    localparam logic [ILV_W-1:0] ILV_BLOCK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END     = 2'd2;

    // Mode bits: bit 0 write, bit 1 block access
    localparam int MODE_WR_BIT  = 0;
    localparam int MODE_BLK_BIT = 1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input beat
        logic div_step;  // one divider cycle
        logic split;     // quotient/remainder into track/sector
        logic eval;      // range check and linear sector
        logic out_load;  // fill result register
        logic next_sec;  // advance to second sector of block
    } dsat_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_last;
    } dsat_sts_t;

    // Logical to physical sector through the selected interleave table
    function automatic logic [3:0] phys_of(input logic [ILV_W-1:0] order,
                                           input logic [3:0] idx);
        logic [3:0] dos;
        logic [3:0] blk;
        case (idx)
            4'h0: dos = 4'h0;  4'h1: dos = 4'h7;  4'h2: dos = 4'hE;  4'h3: dos = 4'h6;
            4'h4: dos = 4'hD;  4'h5: dos = 4'h5;  4'h6: dos = 4'hC;  4'h7: dos = 4'h4;
            4'h8: dos = 4'hB;  4'h9: dos = 4'h3;  4'hA: dos = 4'hA;  4'hB: dos = 4'h2;
            4'hC: dos = 4'h9;  4'hD: dos = 4'h1;  4'hE: dos = 4'h8;  default: dos = 4'hF;
        endcase
        // block order interleaves the two halves of the track
        blk = {idx[0], idx[3:1]};
        case (order)
            ILV_DOS:   phys_of = dos;
            ILV_BLOCK: phys_of = blk;
            default:   phys_of = idx;
        endcase
    endfunction

endpackage

// ----- src/dsat_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsat_ctrl
// Sequencer: accepts an access, runs the block divider for block accesses,
// then evaluates and delivers one or two result beats.
// ----------------------------------------------------------------------------
module dsat_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_block,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dsat_pkg::dsat_cmd_t  cmd,
    input  dsat_pkg::dsat_sts_t  sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_SEND  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_SEND);

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = s_block ? S_DIV : S_EVAL;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                cmd.out_load = 1'b1;
                state_next   = S_SEND;
            end
            S_SEND: begin
                if (m_ready) begin
                    if (sts.out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_sec = 1'b1;
                        state_next   = S_EVAL;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Block accesses go through the divider, sector accesses skip it
    a_block_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && s_valid) |=> (state_reg == S_DIV) == $past(s_block))
        else $error("divider entry does not follow access type");

    // A second result follows only a delivered non-final beat
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEND && m_ready && !sts.out_last) |=> state_reg == S_EVAL)
        else $error("second block sector not started");

    // The divider runs at most its fixed number of cycles
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && sts.div_done) |=> state_reg == S_SPLIT)
        else $error("divider overran");

endmodule

// ----- src/dsat_dpath.sv -----
// ----------------------------------------------------------------------------
// dsat_dpath
// Datapath: configuration registers, radix-16 block divider, range and
// image-end checks, offset scaling and the result register.
// ----------------------------------------------------------------------------
module dsat_dpath #(
    parameter int SECTOR_BYTES = dsat_pkg::SECTOR_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_we,
    input  logic [dsat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsat_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input payload
    input  logic [dsat_pkg::MODE_W-1:0]      s_mode,
    input  logic [dsat_pkg::TRACK_W-1:0]     s_track_num,
    input  logic [dsat_pkg::SECTOR_W-1:0]    s_sector_num,
    input  logic [dsat_pkg::BLOCK_W-1:0]     s_block_num,
    // result payload
    output logic [dsat_pkg::OFFSET_W-1:0]    m_byte_offset,
    output logic                             m_half_index,
    output logic [dsat_pkg::STATUS_W-1:0]    m_status,
    output logic                             m_last,
    output logic                             m_modified,
    // control
    input  dsat_pkg::dsat_cmd_t              cmd,
    output dsat_pkg::dsat_sts_t              sts
);

    localparam int OFF_W = dsat_pkg::LIN_W + $clog2(SECTOR_BYTES + 1);
    localparam logic [dsat_pkg::DIV_CNT_W-1:0] DIV_LAST =
        dsat_pkg::DIV_CNT_W'(dsat_pkg::DIV_CYCLES - 1);

    // Configuration
    logic [dsat_pkg::SPT_W-1:0] spt_reg;
    logic [dsat_pkg::TC_W-1:0]  tc_reg;
    logic [dsat_pkg::ILV_W-1:0] ilv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg <= dsat_pkg::SPT_RST;
            tc_reg  <= dsat_pkg::TC_RST;
            ilv_reg <= dsat_pkg::ILV_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                dsat_pkg::CFG_SPT: spt_reg <= cfg_data[dsat_pkg::SPT_W-1:0];
                dsat_pkg::CFG_TC:  tc_reg  <= cfg_data[dsat_pkg::TC_W-1:0];
                dsat_pkg::CFG_ILV: ilv_reg <= cfg_data[dsat_pkg::ILV_W-1:0];
                default: ;
            endcase
        end
    end

    // Access registers
    logic [dsat_pkg::MODE_W-1:0]   mode_reg;
    logic [dsat_pkg::TRACK_W-1:0]  trk_reg;
    logic [dsat_pkg::SECTOR_W-1:0] sec_reg;
    logic                          half_reg;
    logic [dsat_pkg::BLOCK_W-1:0]  quo_reg;
    logic [dsat_pkg::SPT_W-1:0]    rem_reg;
    logic [dsat_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [dsat_pkg::LIN_W-1:0]    lin_reg;
    logic                          range_bad_reg;
    logic                          room_bad_reg;
    logic                          dirty_reg;
    logic                          dirty_next;

    // Divider: four restoring steps per cycle, remainder stays below spt when spt is nonzero
    logic [dsat_pkg::BLOCK_W-1:0] quo_next;
    logic [dsat_pkg::SPT_W-1:0]   rem_next;
    always_comb begin
        logic [dsat_pkg::SPT_W:0] part_v;
        logic                     ge_v;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < dsat_pkg::DIV_STEPS; i++) begin
            part_v   = {rem_next, quo_next[dsat_pkg::BLOCK_W-1]};
            ge_v     = (part_v >= {1'b0, spt_reg});
            quo_next = {quo_next[dsat_pkg::BLOCK_W-2:0], ge_v};
            if (ge_v) begin
                part_v = part_v - {1'b0, spt_reg};
            end
            rem_next = part_v[dsat_pkg::SPT_W-1:0];
        end
    end

    // Second sector of a block: next sector, or sector 0 of the next track
    logic [dsat_pkg::SECTOR_W:0] sec_inc;
    logic                        sec_wrap;
    assign sec_inc  = {1'b0, sec_reg} + 9'd1;
    assign sec_wrap = !(sec_inc < {4'b0, spt_reg});

    // Range check and linear sector number
    logic [3:0]                 phys;
    logic [dsat_pkg::LIN_W-1:0] lin;
    logic [dsat_pkg::CAP_W-1:0] cap;
    logic                       range_bad;
    assign phys      = dsat_pkg::phys_of(ilv_reg, sec_reg[3:0]);
    assign range_bad = (trk_reg >= {2'b0, tc_reg}) || (sec_reg >= {3'b0, spt_reg});
    assign lin       = dsat_pkg::LIN_W'({5'b0, trk_reg} * {8'b0, spt_reg})
                       + {9'b0, phys};
    assign cap       = dsat_pkg::CAP_W'({5'b0, tc_reg} * {6'b0, spt_reg});

    // Offset scaling and final status
    logic [OFF_W-1:0]              off_full;
    logic [dsat_pkg::STATUS_W-1:0] status_new;
    logic                          ok_new;
    logic                          last_new;
    assign off_full = OFF_W'(lin_reg) * OFF_W'(SECTOR_BYTES);
    always_comb begin
        if (range_bad_reg) begin
            status_new = dsat_pkg::ST_INVALID;
        end else if (room_bad_reg || (|off_full[OFF_W-1:dsat_pkg::OFFSET_W])) begin
            status_new = dsat_pkg::ST_END;
        end else begin
            status_new = dsat_pkg::ST_OK;
        end
    end
    assign ok_new     = (status_new == dsat_pkg::ST_OK);
    assign last_new   = !mode_reg[dsat_pkg::MODE_BLK_BIT] || half_reg || !ok_new;
    assign dirty_next = dirty_reg | (ok_new & mode_reg[dsat_pkg::MODE_WR_BIT]);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg   <= 1'b0;
            half_reg    <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                half_reg    <= 1'b0;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.next_sec) begin
                half_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                dirty_reg <= dirty_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            trk_reg  <= s_track_num;
            sec_reg  <= s_sector_num;
            quo_reg  <= {s_block_num[dsat_pkg::BLOCK_W-2:0], 1'b0};
            rem_reg  <= '0;
        end
        if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.split) begin
            if (spt_reg == '0) begin
                trk_reg <= '0;
                sec_reg <= '0;
            end else begin
                trk_reg <= quo_reg[dsat_pkg::TRACK_W-1:0];
                sec_reg <= {3'b0, rem_reg};
            end
        end
        if (cmd.next_sec) begin
            if (sec_wrap) begin
                trk_reg <= trk_reg + 1'b1;
                sec_reg <= '0;
            end else begin
                sec_reg <= sec_inc[dsat_pkg::SECTOR_W-1:0];
            end
        end
        if (cmd.eval) begin
            lin_reg       <= lin;
            range_bad_reg <= range_bad;
            room_bad_reg  <= !(lin < {2'b0, cap});
        end
        if (cmd.out_load) begin
            m_byte_offset <= ok_new ? off_full[dsat_pkg::OFFSET_W-1:0] : '0;
            m_half_index  <= half_reg;
            m_status      <= status_new;
            m_last        <= last_new;
            m_modified    <= dirty_next;
        end
    end

    assign sts.div_done = (div_cnt_reg == DIV_LAST);
    assign sts.out_last = m_last;

    // Dirty flag is sticky
    a_dirty_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        dirty_reg |=> dirty_reg)
        else $error("modified flag cleared");

    // A failed result carries a zero offset
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.out_load) && m_status != dsat_pkg::ST_OK |-> m_byte_offset == '0)
        else $error("offset not zero on failure");

    // Second sector only exists for block accesses and is always final
    a_half_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && half_reg |-> mode_reg[dsat_pkg::MODE_BLK_BIT] && last_new)
        else $error("second sector outside block access");

endmodule

// ----- src/disk_sector_address_translate_top.sv -----
// ----------------------------------------------------------------------------
// disk_sector_address_translate_top
// Sequence: a sector access passes the evaluate, output-load and send
// states; a block access first runs the 4-bit-per-cycle divider by
// sectors per track and a split state, and gives its second beat through
// evaluate, output-load and send again after the first is taken.
// Throughput: one access at a time, a new one taken once the last beat is.
// Reset: synchronous active low; configuration to 16 sectors, 35 tracks,
// identity interleave, modified flag cleared.
// ----------------------------------------------------------------------------
module disk_sector_address_translate_top #(
    parameter int SECTOR_BYTES = dsat_pkg::SECTOR_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [dsat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsat_pkg::CFG_DATA_W-1:0]  cfg_data,
    // access channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dsat_pkg::MODE_W-1:0]      s_mode,
    input  logic [dsat_pkg::TRACK_W-1:0]     s_track_num,
    input  logic [dsat_pkg::SECTOR_W-1:0]    s_sector_num,
    input  logic [dsat_pkg::BLOCK_W-1:0]     s_block_num,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dsat_pkg::OFFSET_W-1:0]    m_byte_offset,
    output logic                             m_half_index,
    output logic [dsat_pkg::STATUS_W-1:0]    m_status,
    output logic                             m_last,
    output logic                             m_modified
);

    dsat_pkg::dsat_cmd_t cmd;
    dsat_pkg::dsat_sts_t sts;

    dsat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_block (s_mode[dsat_pkg::MODE_BLK_BIT]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    dsat_dpath #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_mode        (s_mode),
        .s_track_num   (s_track_num),
        .s_sector_num  (s_sector_num),
        .s_block_num   (s_block_num),
        .m_byte_offset (m_byte_offset),
        .m_half_index  (m_half_index),
        .m_status      (m_status),
        .m_last        (m_last),
        .m_modified    (m_modified),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
